// ===== hdl/rla_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive line assembler package
// Shared constants for the receive line assembler: store depth, field
// widths and the two line terminator characters.
// ----------------------------------------------------------------------------
package rla_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;

    localparam logic [ADDR_W-1:0] FILL_LIMIT = ADDR_W'(LINE_DEPTH - 1);

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

endpackage

// ===== hdl/rx_line_assembler_core.sv =====
// ----------------------------------------------------------------------------
// Receive line assembler core
// Collects received bytes in a line store and, on a carriage return or a
// line feed, emits the stored line byte by byte; a byte that finds the
// store full is dropped and one overflow request is emitted instead.
// ----------------------------------------------------------------------------
// An ordinary byte is taken and gives no output. A terminator starts the
// line run; its first byte is read from the store in S_READ, loaded in
// S_LOAD and presented in S_SEND. An overflow request is presented in the
// cycle after the dropped byte is taken.
// Throughput: one input byte per cycle while no line run or overflow request
// is pending; in a run each line byte goes through store read, load and send
// in turn, set by the synchronous read of the line store, plus any output stall.
// Reset clears the fill count and the control state; the store is undefined.
module rx_line_assembler_core
    import rla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              line_valid,
    input  logic              line_stall,
    output logic [BYTE_W-1:0] line_byte,
    output logic [LEN_W-1:0]  line_length,
    output logic              last,
    output logic              overflow
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SEND
    } state_t;

    state_t              state_reg,    state_next;
    logic [ADDR_W-1:0]   fill_reg,     fill_next;
    logic [ADDR_W-1:0]   len_reg,      len_next;
    logic [ADDR_W-1:0]   rd_idx_reg,   rd_idx_next;
    logic                valid_reg,    valid_next;
    logic [BYTE_W-1:0]   byte_reg,     byte_next;
    logic [LEN_W-1:0]    length_reg,   length_next;
    logic                last_reg,     last_next;
    logic                overflow_reg, overflow_next;

    logic [BYTE_W-1:0]   store_mem [LINE_DEPTH];
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                wr_en;
    logic                take;
    logic                is_term;

    assign rx_stall = !((state_reg == S_IDLE) ||
                        ((state_reg == S_SEND) && last_reg && !line_stall));
    assign take     = rx_valid && !rx_stall;
    assign is_term  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        rd_idx_next   = rd_idx_reg;
        valid_next    = valid_reg;
        byte_next     = byte_reg;
        length_next   = length_reg;
        last_next     = last_reg;
        overflow_next = overflow_reg;
        wr_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                byte_next     = rd_data_reg;
                length_next   = LEN_W'(len_reg);
                last_next     = (ADDR_W'(rd_idx_reg + 1'b1) == len_reg);
                overflow_next = 1'b0;
                valid_next    = 1'b1;
                state_next    = S_SEND;
            end
            S_SEND:
            begin
                if (!line_stall)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = ADDR_W'(rd_idx_reg + 1'b1);
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (take)
        begin
            if (fill_reg < FILL_LIMIT)
            begin
                wr_en = 1'b1;
                if (is_term)
                begin
                    len_next    = ADDR_W'(fill_reg + 1'b1);
                    rd_idx_next = '0;
                    fill_next   = '0;
                    state_next  = S_READ;
                end
                else
                begin
                    fill_next  = ADDR_W'(fill_reg + 1'b1);
                    state_next = S_IDLE;
                end
            end
            else
            begin
                fill_next     = '0;
                byte_next     = '0;
                length_next   = '0;
                last_next     = 1'b1;
                overflow_next = 1'b1;
                valid_next    = 1'b1;
                state_next    = S_SEND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            len_reg      <= '0;
            rd_idx_reg   <= '0;
            valid_reg    <= 1'b0;
            byte_reg     <= '0;
            length_reg   <= '0;
            last_reg     <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            rd_idx_reg   <= rd_idx_next;
            valid_reg    <= valid_next;
            byte_reg     <= byte_next;
            length_reg   <= length_next;
            last_reg     <= last_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[fill_reg] <= rx_byte;
        end
        rd_data_reg <= store_mem[rd_idx_reg];
    end

    assign line_valid  = valid_reg;
    assign line_byte   = byte_reg;
    assign line_length = length_reg;
    assign last        = last_reg;
    assign overflow    = overflow_reg;

endmodule

// ===== tb/tb_rx_line_assembler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive line assembler testbench
// Feeds received bytes into the line assembler and checks every line request
// against a line model kept in a scoreboard. The run covers short and empty
// lines, the longest line, a full store hit by a terminator and by an
// ordinary byte, random noise, and random idling on both sides, including
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_rx_line_assembler_core;
    import rla_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              fin;
        logic              ovf;
    } line_result_t;

    class line_scoreboard;
        logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
        logic [LEN_W-1:0]  fill;
        line_result_t      line_q[$];
        int                errors;
        int                bytes_taken;
        int                results_seen;
        int                lines_seen;
        int                overflows_seen;

        function new();
            fill           = '0;
            errors         = 0;
            bytes_taken    = 0;
            results_seen   = 0;
            lines_seen     = 0;
            overflows_seen = 0;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] ch);
            line_result_t r;
            bytes_taken++;
            if (fill < FILL_LIMIT)
            begin
                line_mem[fill] = ch;
                fill = fill + 1'b1;
                if (ch == CHAR_CR || ch == CHAR_LF)
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        r.data = line_mem[i];
                        r.len  = fill;
                        r.fin  = (i == fill - 1);
                        r.ovf  = 1'b0;
                        line_q.push_back(r);
                    end
                    fill = '0;
                end
            end
            else
            begin
                fill  = '0;
                r.data = '0;
                r.len  = '0;
                r.fin  = 1'b1;
                r.ovf  = 1'b1;
                line_q.push_back(r);
            end
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic [LEN_W-1:0] len,
                                   logic fin, logic ovf);
            line_result_t want;
            results_seen++;
            if (line_q.size() == 0)
            begin
                $error("Unexpected line request: line_byte %0h line_length %0d", data, len);
                errors++;
                return;
            end
            want = line_q.pop_front();
            if (fin === 1'b1)
            begin
                if (ovf === 1'b1)
                    overflows_seen++;
                else
                    lines_seen++;
            end
            if (data !== want.data)
            begin
                $error("line_byte: expected %0h, actual %0h", want.data, data);
                errors++;
            end
            if (len !== want.len)
            begin
                $error("line_length: expected %0d, actual %0d", want.len, len);
                errors++;
            end
            if (fin !== want.fin)
            begin
                $error("last: expected %0b, actual %0b", want.fin, fin);
                errors++;
            end
            if (ovf !== want.ovf)
            begin
                $error("overflow: expected %0b, actual %0b", want.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    localparam int HOLD_CYCLES = 400;

    logic              clk;
    logic              rst_n;
    logic              rx_valid;
    logic              rx_stall;
    logic [BYTE_W-1:0] rx_byte;
    logic              line_valid;
    logic              line_stall;
    logic [BYTE_W-1:0] line_byte;
    logic [LEN_W-1:0]  line_length;
    logic              last;
    logic              overflow;

    line_scoreboard sb;
    bit             calm;
    bit             hold_req;
    int             items_sent;

    rx_line_assembler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .line_valid  (line_valid),
        .line_stall  (line_stall),
        .line_byte   (line_byte),
        .line_length (line_length),
        .last        (last),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_plain();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_term();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (rx_stall);
        sb.take_byte(b);
        items_sent++;
    endtask

    task automatic send_line(input int plain_count, input logic [BYTE_W-1:0] term);
        repeat (plain_count) send_byte(pick_plain());
        send_byte(term);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        line_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && line_valid && !line_stall)
                sb.check_result(line_byte, line_length, last, overflow);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                line_stall <= 1'b1;
            end
            else
            begin
                line_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int r;
        sb         = new();
        calm       = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        rst_n    <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty lines, byte extremes and values one bit away from the terminators.
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_byte(8'h0C);
        send_byte(8'h0E);
        send_byte(8'h8D);
        send_byte(8'h8A);
        send_byte(8'h0B);
        send_byte(8'h09);
        send_byte(CHAR_LF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);

        // The longest line is sent while the output is held off for a long time.
        hold_req = 1'b1;
        send_line(LINE_DEPTH - 2, pick_term());
        // A full store drops the terminator and reports an overflow.
        send_line(LINE_DEPTH - 1, pick_term());
        // A full store hit by an ordinary byte overflows before the terminator.
        send_line(LINE_DEPTH, pick_term());

        while (items_sent < 220)
        begin
            calm = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 75)
                send_line($urandom_range(0, 10), pick_term());
            else if (r < 83)
                send_line($urandom_range(56, 66), pick_term());
            else
                repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        calm = 1'b0;
        rx_valid <= 1'b0;

        while (sb.line_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d received bytes and %0d line requests:",
                 sb.bytes_taken, sb.results_seen);
        $display("%0d lines and %0d overflows.", sb.lines_seen, sb.overflows_seen);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rla_pkg.sv
hdl/rx_line_assembler_core.sv
tb/tb_rx_line_assembler_core.sv
